// File: rtl/bcsc_pkg.sv
package bcsc_pkg;

   // fixed field widths
   localparam int SPEED_W = 8;
   localparam int DIST_W  = 24;
   localparam int TICKS_W = 16;
   localparam int LIMIT_W = 8;
   localparam int DECEL_W = 12;
   localparam int ACCEL_W = 16;
   localparam int MAG_W   = 16;

   // configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] REG_DECEL = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_ACCEL = 1'b1;
   localparam logic [DECEL_W-1:0] DECEL_RESET = 12'd16;
   localparam logic [ACCEL_W-1:0] ACCEL_RESET = 16'd256;

   // accumulator format: sign, 16 integer bits, FRACTION_BITS fraction bits
   localparam int FRACTION_BITS = 8;
   localparam int ACC_W      = 17 + FRACTION_BITS;
   localparam int CMD_W      = ACC_W - FRACTION_BITS;
   localparam int UP_SHIFT   = (FRACTION_BITS >= 8) ? FRACTION_BITS - 8 : 0;
   localparam int DOWN_SHIFT = (FRACTION_BITS < 8) ? 8 - FRACTION_BITS : 0;
   localparam int RATE_W     = ACCEL_W + TICKS_W;
   localparam int INC_W      = RATE_W + UP_SHIFT;
   localparam int SUM_W      = ((INC_W > ACC_W) ? INC_W : ACC_W) + 2;

   // braking test and root operand
   localparam int PROD_W      = DIST_W + DECEL_W;
   localparam int VSQ_W       = 2 * SPEED_W;
   localparam int VSQ80_W     = VSQ_W + 5;
   localparam int SCALE_SHIFT = 4;   // 80 = 16 * 5
   localparam int WORK_W      = PROD_W - SCALE_SHIFT;
   // floor(x/5) for any 32-bit x: (x * ceil(2^34/5)) >> 34
   localparam logic [WORK_W-1:0] DIV5_RECIP = 32'hCCCC_CCCD;
   localparam int DIV5_SHIFT  = 34;
   // quotient stays below 2^30, so the first root bit is 2^28
   localparam int ROOT_TOP    = 28;
   localparam int ROOT_STEPS  = ROOT_TOP / 2 + 1;
   localparam int STEP_CNT_W  = 5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULTIPLY,
      ST_DECIDE,
      ST_DIVIDE,
      ST_ROOT,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic load_item;
      logic multiply;
      logic decide;
      logic div_step;
      logic root_step;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic brake;
      logic out_free;
   } ctrl_status_type;

endpackage

// File: rtl/bcsc_if.sv
interface bcsc_req_if import bcsc_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic signed [SPEED_W-1:0] measured_speed;
   logic [DIST_W-1:0]         distance_left;
   logic [TICKS_W-1:0]        elapsed_ticks;
   logic [LIMIT_W-1:0]        segment_limit;

   modport source (output valid, measured_speed, distance_left, elapsed_ticks, segment_limit,
                   input ready);
   modport sink (input valid, measured_speed, distance_left, elapsed_ticks, segment_limit,
                 output ready);
endinterface

interface bcsc_rsp_if import bcsc_pkg::*;;
   logic             valid;
   logic             ready;
   logic [MAG_W-1:0] speed_magnitude;
   logic             forward;
   logic             braking;
   logic             limited;

   modport source (output valid, speed_magnitude, forward, braking, limited, input ready);
   modport sink (input valid, speed_magnitude, forward, braking, limited, output ready);
endinterface

interface bcsc_csr_if import bcsc_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/bcsc_controller.sv
module bcsc_controller import bcsc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   state_type             state_ff, state_in;
   logic [STEP_CNT_W-1:0] count_ff, count_in;
   logic                  root_last;

   assign root_last = (count_ff == STEP_CNT_W'(ROOT_STEPS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_MULTIPLY;
         end
         ST_MULTIPLY: state_in = ST_DECIDE;
         ST_DECIDE: begin
            state_in = status.brake ? ST_DIVIDE : ST_COMMIT;
         end
         ST_DIVIDE: state_in = ST_ROOT;
         ST_ROOT: begin
            if (root_last) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // step counter for the root loop
   always_comb begin
      count_in = '0;
      if (state_ff == ST_ROOT && !root_last) begin
         count_in = count_ff + STEP_CNT_W'(1);
      end
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         ST_MULTIPLY: cmd.multiply = 1'b1;
         ST_DECIDE:   cmd.decide = 1'b1;
         ST_DIVIDE:   cmd.div_step = 1'b1;
         ST_ROOT:     cmd.root_step = 1'b1;
         ST_COMMIT:   cmd.commit = status.out_free;
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/bcsc_datapath.sv
module bcsc_datapath import bcsc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  ctrl_cmd_type              cmd,
   output ctrl_status_type           status,
   input  logic signed [SPEED_W-1:0] req_measured_speed,
   input  logic [DIST_W-1:0]         req_distance_left,
   input  logic [TICKS_W-1:0]        req_elapsed_ticks,
   input  logic [LIMIT_W-1:0]        req_segment_limit,
   input  logic                      csr_valid,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [MAG_W-1:0]          rsp_speed_magnitude,
   output logic                      rsp_forward,
   output logic                      rsp_braking,
   output logic                      rsp_limited
);

   localparam logic signed [ACC_W-1:0] ACC_MAX    = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] TRUNC_BIAS = ACC_W'((1 << FRACTION_BITS) - 1);
   localparam logic [WORK_W-1:0]       ROOT_BIT0  = WORK_W'(1) << ROOT_TOP;

   // configuration
   logic [DECEL_W-1:0] decel_ff;
   logic [ACCEL_W-1:0] accel_ff;

   // captured word
   logic signed [SPEED_W-1:0] speed_ff;
   logic [DIST_W-1:0]         dist_ff;
   logic [TICKS_W-1:0]        ticks_ff;
   logic [LIMIT_W-1:0]        limit_ff;

   // products
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [VSQ80_W-1:0] vsq80_ff, vsq80_in;
   logic [INC_W-1:0]   inc_ff, inc_in;
   logic signed [VSQ_W-1:0] vsq;
   logic [RATE_W-1:0]  rate;

   // accumulator
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] acc_sum_ff, acc_sum_in;
   logic signed [SUM_W-1:0] sum_wide;
   logic                    brake_ff;

   // divide-by-five and root
   logic [WORK_W-1:0]   work_ff;
   logic [WORK_W-1:0]   res_ff, res_in;
   logic [WORK_W-1:0]   bit_ff;
   logic [WORK_W-1:0]   trial;
   logic [2*WORK_W-1:0] recip_prod;

   // result
   logic signed [ACC_W-1:0] biased;
   logic signed [CMD_W-1:0] cmd_acc, cmd_root, cmd_sel, cmd_final, cmd_abs, limit_s;
   logic                    clamp;

   logic             rsp_valid_ff;
   logic [MAG_W-1:0] mag_ff;
   logic             forward_ff, braking_ff, limited_ff;

   // multiply stage
   assign vsq      = VSQ_W'(speed_ff) * VSQ_W'(speed_ff);
   assign vsq80_in = (VSQ80_W'($unsigned(vsq)) << 6) + (VSQ80_W'($unsigned(vsq)) << 4);
   assign prod_in  = PROD_W'(dist_ff) * PROD_W'(decel_ff);
   assign rate     = RATE_W'(accel_ff) * RATE_W'(ticks_ff);
   assign inc_in   = (INC_W'(rate) << UP_SHIFT) >> DOWN_SHIFT;

   // saturating accumulate
   assign sum_wide   = SUM_W'(acc_ff) + $signed(SUM_W'(inc_ff));
   assign acc_sum_in = (sum_wide > SUM_W'(ACC_MAX)) ? ACC_MAX : ACC_W'(sum_wide);

   assign status.brake    = (prod_ff <= PROD_W'(vsq80_ff));
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // divide by five as a reciprocal multiply, exact over the whole operand range
   assign recip_prod = (2*WORK_W)'(work_ff) * (2*WORK_W)'(DIV5_RECIP);

   // digit-by-digit square root, radicand held in work_ff
   assign trial = res_ff + bit_ff;
   assign res_in = (work_ff >= trial) ? (res_ff >> 1) + bit_ff : res_ff >> 1;

   // command, truncated toward zero, then clamped
   assign biased    = acc_sum_ff + (acc_sum_ff[ACC_W-1] ? TRUNC_BIAS : ACC_W'(0));
   assign cmd_acc   = $signed(biased[ACC_W-1:FRACTION_BITS]);
   assign cmd_root  = $signed(CMD_W'(res_ff[MAG_W-1:0]));
   assign cmd_sel   = brake_ff ? cmd_root : cmd_acc;
   assign limit_s   = $signed(CMD_W'(limit_ff));
   assign clamp     = (cmd_sel > limit_s);
   assign cmd_final = clamp ? limit_s : cmd_sel;
   assign cmd_abs   = (cmd_final < 0) ? -cmd_final : cmd_final;

   always_comb begin
      if (clamp) begin
         acc_in = $signed(ACC_W'(limit_ff) << FRACTION_BITS);
      end else if (brake_ff) begin
         acc_in = ACC_W'(speed_ff) <<< FRACTION_BITS;
      end else begin
         acc_in = acc_sum_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         decel_ff     <= DECEL_RESET;
         accel_ff     <= ACCEL_RESET;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            if (csr_index == REG_DECEL) begin
               decel_ff <= csr_data[DECEL_W-1:0];
            end else if (csr_index == REG_ACCEL) begin
               accel_ff <= csr_data[ACCEL_W-1:0];
            end
         end
         if (cmd.commit) begin
            acc_ff       <= acc_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         speed_ff <= req_measured_speed;
         dist_ff  <= req_distance_left;
         ticks_ff <= req_elapsed_ticks;
         limit_ff <= req_segment_limit;
      end
      if (cmd.multiply) begin
         prod_ff  <= prod_in;
         vsq80_ff <= vsq80_in;
         inc_ff   <= inc_in;
      end
      if (cmd.decide) begin
         brake_ff   <= status.brake;
         acc_sum_ff <= acc_sum_in;
         work_ff    <= prod_ff[PROD_W-1:SCALE_SHIFT];
         res_ff     <= '0;
         bit_ff     <= ROOT_BIT0;
      end
      if (cmd.div_step) begin
         work_ff <= WORK_W'(recip_prod[2*WORK_W-1:DIV5_SHIFT]);
      end
      if (cmd.root_step) begin
         if (work_ff >= trial) work_ff <= work_ff - trial;
         res_ff <= res_in;
         bit_ff <= bit_ff >> 2;
      end
      if (cmd.commit) begin
         mag_ff     <= cmd_abs[MAG_W-1:0];
         forward_ff <= (cmd_final > 0);
         braking_ff <= brake_ff;
         limited_ff <= clamp;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_speed_magnitude = mag_ff;
   assign rsp_forward         = forward_ff;
   assign rsp_braking         = braking_ff;
   assign rsp_limited         = limited_ff;

endmodule

// File: rtl/braking_curve_speed_command_core.sv
// braking-curve speed command: each request word (measured speed, distance left, elapsed
// ticks, segment limit) yields one response word. when distance*decel <= 80*v^2 the core
// brakes, commands floor(sqrt(decel*distance/80)) and loads the accumulator with v; otherwise
// it adds accel_rate*ticks to a saturating signed accumulator and commands its value
// truncated toward zero. a command above the limit is clamped and the accumulator reset to
// the limit. one word is in flight at a time: a braking word passes through multiply, decide,
// a reciprocal divide by five, 15 steps of the square root and commit; an accelerating word
// passes through multiply, decide and commit. the next request is taken the cycle after
// commit. a finished response sits in the output register while the next request is taken;
// commit waits only if that register is still full. csr writes (index 0 decel, index 1 accel)
// are always accepted and must only be issued while the core is idle.
module braking_curve_speed_command_core import bcsc_pkg::*; (
   input logic        clock,
   input logic        reset,
   bcsc_req_if.sink   req_channel,
   bcsc_rsp_if.source rsp_channel,
   bcsc_csr_if.sink   csr_channel
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // csr writes are always accepted
   assign csr_channel.ready = 1'b1;

   // sequencer: capture, multiply, decide, divide, root, commit
   bcsc_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_channel.valid),
      .req_ready (req_channel.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic, accumulator, config registers and output register
   bcsc_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_measured_speed  (req_channel.measured_speed),
      .req_distance_left   (req_channel.distance_left),
      .req_elapsed_ticks   (req_channel.elapsed_ticks),
      .req_segment_limit   (req_channel.segment_limit),
      .csr_valid           (csr_channel.valid),
      .csr_index           (csr_channel.index),
      .csr_data            (csr_channel.data),
      .rsp_valid           (rsp_channel.valid),
      .rsp_ready           (rsp_channel.ready),
      .rsp_speed_magnitude (rsp_channel.speed_magnitude),
      .rsp_forward         (rsp_channel.forward),
      .rsp_braking         (rsp_channel.braking),
      .rsp_limited         (rsp_channel.limited)
   );

endmodule

// File: test/braking_curve_speed_command_core_tb.sv
`timescale 1ns / 1ps

module braking_curve_speed_command_core_tb import bcsc_pkg::*;;

   // one measurement word in, one speed command word out
   typedef struct packed {
      logic signed [SPEED_W-1:0] speed;
      logic [DIST_W-1:0]         distance;
      logic [TICKS_W-1:0]        ticks;
      logic [LIMIT_W-1:0]        limit;
   } speed_report_type;

   typedef struct packed {
      logic [MAG_W-1:0] magnitude;
      logic             forward;
      logic             braking;
      logic             limited;
   } speed_cmd_type;

   // largest accumulator value, sign bit clear
   localparam longint ACC_TOP     = (longint'(1) << (16 + FRACTION_BITS)) - 1;
   // longest quiet stretch is a braking word behind the long output hold
   localparam int     QUIET_LIMIT = 3000;
   localparam int     HOLD_CYCLES = 400;
   localparam int     GAP_PCT     = 6;

   logic clock = 1'b0;
   logic reset;

   bcsc_req_if req_bus ();
   bcsc_rsp_if rsp_bus ();
   bcsc_csr_if csr_bus ();

   braking_curve_speed_command_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_bus.sink),
      .rsp_channel (rsp_bus.source),
      .csr_channel (csr_bus.sink)
   );

   // shadow copy of the registers and the speed accumulator
   logic [DECEL_W-1:0] decel_shadow;
   logic [ACCEL_W-1:0] accel_shadow;
   longint             accum_model;

   speed_cmd_type cmd_expect_q[$];
   speed_cmd_type last_command;
   int            mismatch_count = 0;
   int            quiet_cycles   = 0;

   // random idling on both sides, and the long receiver hold request
   bit gaps_on     = 1'b1;
   bit hold_toggle = 1'b0;
   bit hold_seen;
   int hold_left;

   initial forever #4 clock = ~clock;

   // exact floor of the square root, one bit at a time from the top
   function automatic longint unsigned floor_root(input longint unsigned x);
      longint unsigned root, trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (longint'(1) << b);
         if (trial * trial <= x) root = trial;
      end
      return root;
   endfunction

   // expected command for one accepted word; advances the accumulator copy
   function automatic speed_cmd_type predict_command(input speed_report_type r);
      speed_cmd_type   res;
      longint          v, cmd, lim, mag_full;
      longint unsigned prod, curve, inc;
      v     = longint'($signed(r.speed));
      lim   = longint'(r.limit);
      prod  = longint'(r.distance) * decel_shadow;
      curve = longint'(80) * v * v;
      res.braking = (prod <= curve);
      if (res.braking) begin
         // inside the braking curve: root of the scaled distance, accumulator takes v
         cmd         = longint'(floor_root(prod / 80));
         accum_model = v * (longint'(1) << FRACTION_BITS);
      end else begin
         // accelerate: rate times ticks, rescaled to the accumulator fraction, saturating
         inc = longint'(accel_shadow) * r.ticks;
         inc = (inc << UP_SHIFT) >> DOWN_SHIFT;
         if (inc > ACC_TOP || accum_model > ACC_TOP - longint'(inc))
            accum_model = ACC_TOP;
         else
            accum_model = accum_model + longint'(inc);
         // signed division truncates toward zero
         cmd = accum_model / (longint'(1) << FRACTION_BITS);
      end
      // clamp only from above, so a negative command is never limited
      res.limited = (cmd > lim);
      if (res.limited) begin
         cmd         = lim;
         accum_model = lim * (longint'(1) << FRACTION_BITS);
      end
      mag_full      = (cmd < 0) ? -cmd : cmd;
      res.magnitude = MAG_W'(mag_full);
      res.forward   = (cmd > 0);
      return res;
   endfunction

   function automatic speed_report_type make_report(input int speed, input int distance,
                                                    input int ticks, input int lim);
      speed_report_type r;
      r.speed    = SPEED_W'(speed);
      r.distance = DIST_W'(distance);
      r.ticks    = TICKS_W'(ticks);
      r.limit    = LIMIT_W'(lim);
      return r;
   endfunction

   // random word, biased toward the braking curve and modest tick counts
   function automatic speed_report_type random_report();
      speed_report_type r;
      longint           boundary, v;
      int               pick;
      r.speed = SPEED_W'($urandom);
      r.limit = LIMIT_W'($urandom);
      v       = longint'($signed(r.speed));
      pick    = $urandom_range(99);
      if (pick < 40 && decel_shadow != 0) begin
         // a few units either side of the braking distance
         boundary = longint'(80) * v * v / decel_shadow;
         boundary = boundary + longint'($urandom_range(6)) - 3;
         if (boundary < 0) boundary = 0;
         if (boundary > longint'({DIST_W{1'b1}})) boundary = longint'({DIST_W{1'b1}});
         r.distance = DIST_W'(boundary);
      end else if (pick < 65) begin
         r.distance = DIST_W'($urandom_range(4000));
      end else if (pick < 92) begin
         r.distance = DIST_W'($urandom);
      end else begin
         r.distance = $urandom_range(1) ? '0 : '1;
      end
      pick = $urandom_range(99);
      if (pick < 50)
         r.ticks = TICKS_W'($urandom_range(15));
      else if (pick < 80)
         r.ticks = TICKS_W'($urandom_range(1023));
      else if (pick < 95)
         r.ticks = TICKS_W'($urandom);
      else
         r.ticks = $urandom_range(1) ? '0 : '1;
      return r;
   endfunction

   // offer one word, holding valid across back-to-back words
   task automatic send_word(input speed_report_type r);
      while (gaps_on && $urandom_range(99) < GAP_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.measured_speed <= r.speed;
      req_bus.distance_left  <= r.distance;
      req_bus.elapsed_ticks  <= r.ticks;
      req_bus.segment_limit  <= r.limit;
      do @(posedge clock); while (!req_bus.ready);
      last_command = predict_command(r);
      cmd_expect_q.push_back(last_command);
   endtask

   // leaves csr valid high; set_config lowers it after the last write
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      if (idx == REG_DECEL)
         decel_shadow = value[DECEL_W-1:0];
      else
         accel_shadow = value[ACCEL_W-1:0];
   endtask

   // only called with nothing in flight
   task automatic set_config(input logic [CSR_DATA_W-1:0] decel_word,
                             input logic [ACCEL_W-1:0] accel_word);
      write_reg(REG_DECEL, decel_word);
      write_reg(REG_ACCEL, CSR_DATA_W'(accel_word));
      csr_bus.valid <= 1'b0;
   endtask

   // stop offering and wait for every pending command word
   task automatic drain_commands();
      req_bus.valid <= 1'b0;
      while (cmd_expect_q.size() != 0) @(posedge clock);
   endtask

   // reset register values: extremes of the fields, braking and accelerating
   task automatic test_directed_defaults();
      send_word(make_report(0, 0, 0, 0));
      send_word(make_report(127, 0, 0, 255));
      send_word(make_report(0, 24'hFFFFFF, 0, 255));
      // accumulator saturates, then the clamp pulls it to the limit
      send_word(make_report(0, 24'hFFFFFF, 65535, 255));
      // negative speed loaded on braking, then a negative command
      send_word(make_report(-128, 0, 0, 255));
      send_word(make_report(0, 24'hFFFFFF, 10, 255));
      send_word(make_report(0, 24'hFFFFFF, 0, 0));
      send_word(make_report(127, 1000000, 5, 0));
      // just inside the braking curve, then exactly on it and just outside
      send_word(make_report(127, 80000, 0, 255));
      send_word(make_report(127, 80000, 0, 100));
      send_word(make_report(-1, 5, 7, 3));
      send_word(make_report(-1, 6, 7, 3));
      drain_commands();
   endtask

   // zero deceleration: the curve test always holds and the command is zero
   task automatic test_zero_decel();
      set_config('0, ACCEL_RESET);
      send_word(make_report(5, 24'hFFFFFF, 100, 255));
      send_word(make_report(-128, 123456, 0, 255));
      send_word(make_report(0, 0, 65535, 0));
      drain_commands();
   endtask

   task automatic test_config_extremes();
      set_config(CSR_DATA_W'({DECEL_W{1'b1}}), '1);
      send_word(make_report(127, 320, 0, 255));
      // rate times ticks alone is past the accumulator range
      send_word(make_report(127, 321, 65535, 255));
      send_word(make_report(-128, 24'hFFFFFF, 1, 200));
      drain_commands();
      set_config(CSR_DATA_W'(1), '0);
      send_word(make_report(1, 80, 9, 10));
      send_word(make_report(0, 24'hFFFFFF, 65535, 255));
      drain_commands();
   endtask

   // receiver holds off while words keep coming, so the core backs up
   task automatic test_output_stall();
      set_config(CSR_DATA_W'(DECEL_RESET), ACCEL_RESET);
      hold_toggle <= ~hold_toggle;
      repeat (30) send_word(random_report());
      drain_commands();
   endtask

   task automatic test_random_mix(input int phases, input int per_phase);
      logic [ACCEL_W-1:0] accel_pick;
      for (int p = 0; p < phases; p++) begin
         accel_pick = $urandom_range(1) ? ACCEL_W'($urandom_range(600)) : ACCEL_W'($urandom);
         case (p)
            0:       set_config(CSR_DATA_W'(1), '0);
            1:       set_config(CSR_DATA_W'({$urandom, {DECEL_W{1'b1}}}), '1);
            default: set_config(CSR_DATA_W'({$urandom, DECEL_W'($urandom_range(4095, 1))}),
                                accel_pick);
         endcase
         // one phase runs without any idling on either side
         if (p == 3) gaps_on <= 1'b0;
         repeat (per_phase) send_word(random_report());
         drain_commands();
         if (p == 3) gaps_on <= 1'b1;
      end
   endtask

   // closing on a target: distance shrinks, measured speed follows the command
   task automatic test_approach_runs(input int runs, input int run_len);
      speed_report_type r;
      longint           span;
      int               v;
      for (int n = 0; n < runs; n++) begin
         set_config(CSR_DATA_W'($urandom_range(400, 4)), ACCEL_W'($urandom_range(2000)));
         v       = $urandom_range(1) ? int'($urandom_range(127)) : -int'($urandom_range(20));
         span    = longint'(80) * v * v / decel_shadow + longint'($urandom_range(4000));
         r.limit = LIMIT_W'($urandom_range(255, 30));
         for (int k = 0; k < run_len; k++) begin
            if ($urandom_range(99) < 15) begin
               // noise word in the middle of a run
               send_word(random_report());
            end else begin
               r.speed    = SPEED_W'(v);
               r.distance = DIST_W'(span);
               r.ticks    = TICKS_W'($urandom_range(50));
               send_word(r);
            end
            span = span - longint'($urandom_range(int'(span / 6) + 3));
            if (span < 0) span = 0;
            v = last_command.forward ? int'(last_command.magnitude)
                                     : -int'(last_command.magnitude);
            v = v + int'($urandom_range(4)) - 2;
            if (v > 127) v = 127;
            if (v < -128) v = -128;
         end
         drain_commands();
      end
   endtask

   // response side: random ready, plus the long hold when requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= 0;
         hold_seen     <= 1'b0;
      end else if (hold_seen != hold_toggle) begin
         hold_seen     <= hold_toggle;
         hold_left     <= HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left     <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= !(gaps_on && $urandom_range(99) < GAP_PCT);
      end
   end

   function automatic int field_diff(input string name, input logic [MAG_W-1:0] want,
                                     input logic [MAG_W-1:0] got);
      if (want === got) return 0;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      return 1;
   endfunction

   // compare every accepted command word against the oldest prediction
   always @(posedge clock) begin : check_commands
      speed_cmd_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (cmd_expect_q.size() == 0) begin
            $display("%0t: command word with nothing pending, expected none, got %0d/%0b/%0b/%0b",
                     $time, rsp_bus.speed_magnitude, rsp_bus.forward, rsp_bus.braking,
                     rsp_bus.limited);
            mismatch_count++;
         end else begin
            want = cmd_expect_q.pop_front();
            mismatch_count += field_diff("speed_magnitude", want.magnitude,
                                         rsp_bus.speed_magnitude);
            mismatch_count += field_diff("forward", MAG_W'(want.forward),
                                         MAG_W'(rsp_bus.forward));
            mismatch_count += field_diff("braking", MAG_W'(want.braking),
                                         MAG_W'(rsp_bus.braking));
            mismatch_count += field_diff("limited", MAG_W'(want.limited),
                                         MAG_W'(rsp_bus.limited));
         end
      end
   end

   // watchdog: any handshake on any channel counts as progress
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      reset                  <= 1'b1;
      req_bus.valid          <= 1'b0;
      req_bus.measured_speed <= '0;
      req_bus.distance_left  <= '0;
      req_bus.elapsed_ticks  <= '0;
      req_bus.segment_limit  <= '0;
      csr_bus.valid          <= 1'b0;
      csr_bus.index          <= REG_DECEL;
      csr_bus.data           <= '0;
      decel_shadow = DECEL_RESET;
      accel_shadow = ACCEL_RESET;
      accum_model  = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_directed_defaults();
      test_zero_decel();
      test_config_extremes();
      test_output_stall();
      test_random_mix(6, 105);
      test_approach_runs(12, 20);

      // let any stray command word show up before the verdict
      repeat (60) @(posedge clock);
      if (mismatch_count == 0 && cmd_expect_q.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: braking_curve_speed_command_core.f
rtl/bcsc_pkg.sv
rtl/bcsc_if.sv
rtl/bcsc_controller.sv
rtl/bcsc_datapath.sv
rtl/braking_curve_speed_command_core.sv
test/braking_curve_speed_command_core_tb.sv
